// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property checks with synchronous reset disable; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(name, clk, rst, prop, msg)
`define ASSERT_NEVER(name, clk, rst, expr, msg)
`endif
`endif

// ===== hdl/lrc_pkg.sv =====
// ---------------------------------------------------------------------------
// lrc_pkg
// Shared types and constants of the LRC frame receiver.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lrc_pkg;

   localparam int MAX_PAYLOAD_DEF = 32;

   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 6;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] REG_START_BYTE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PAYLOAD_LEN = 1'd1;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_MISMATCH = 1'b1;

   typedef enum logic [2:0] {
      ST_HUNT,
      ST_COLLECT,
      ST_READ,
      ST_SHOW_DATA,
      ST_SHOW_ERROR
   } state_type;

   typedef struct packed {
      logic frame_start;
      logic store_byte;
      logic frame_pass;
      logic frame_fail;
      logic rd_advance;
      logic sel_error;
   } ctl_cmd_type;

   typedef struct packed {
      logic start_match;
      logic index_full;
      logic sum_ok;
      logic last_read;
   } ctl_status_type;

endpackage

// ===== hdl/lrc_if.sv =====
// ---------------------------------------------------------------------------
// lrc_req_if / lrc_rsp_if
// Valid/ready channels for received bytes and released frame words.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lrc_req_if;
   logic                         valid;
   logic                         ready;
   logic [lrc_pkg::BYTE_W-1:0]   rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lrc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [lrc_pkg::BYTE_W-1:0]   payload_byte;
   logic                         status;
   logic                         last_of_frame;

   modport source (output valid, output payload_byte, output status,
                   output last_of_frame, input ready);
   modport sink   (input valid, input payload_byte, input status,
                   input last_of_frame, output ready);
endinterface

// ===== hdl/lrc_datapath.sv =====
// ---------------------------------------------------------------------------
// lrc_datapath
// Config registers, frame counters, LRC accumulator and frame store.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrc_datapath #(
   parameter int MAX_PAYLOAD = lrc_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wen,
   input  logic [lrc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lrc_pkg::BYTE_W-1:0]      csr_wdata,
   input  logic [lrc_pkg::BYTE_W-1:0]      rx_byte,
   input  lrc_pkg::ctl_cmd_type            cmd,
   output lrc_pkg::ctl_status_type         stat,
   output logic [lrc_pkg::BYTE_W-1:0]      payload_byte,
   output logic                            status,
   output logic                            last_of_frame
);

   localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int CNT_W = lrc_pkg::LEN_W + 1;
   localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_PAYLOAD);

   logic [lrc_pkg::BYTE_W-1:0] start_byte_ff, start_byte_in;
   logic [lrc_pkg::LEN_W-1:0]  payload_len_ff, payload_len_in;
   logic [lrc_pkg::LEN_W-1:0]  byte_index_ff, byte_index_in;
   logic [lrc_pkg::BYTE_W-1:0] running_sum_ff, running_sum_in;
   logic [lrc_pkg::LEN_W-1:0]  rel_count_ff, rel_count_in;
   logic [lrc_pkg::LEN_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [lrc_pkg::BYTE_W-1:0] rd_data_ff;
   logic [lrc_pkg::BYTE_W-1:0] frame_store [MAX_PAYLOAD];

   logic [CNT_W-1:0]           eff_len;
   logic [lrc_pkg::BYTE_W-1:0] sum_next;

   always_comb begin
      start_byte_in  = start_byte_ff;
      payload_len_in = payload_len_ff;
      if (csr_wen) begin
         unique case (csr_index)
            lrc_pkg::REG_START_BYTE:  start_byte_in  = csr_wdata;
            lrc_pkg::REG_PAYLOAD_LEN: payload_len_in = csr_wdata[lrc_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      eff_len = {1'b0, payload_len_ff};
      if (eff_len == '0) begin
         eff_len = CNT_W'(1);
      end else if (eff_len > MAX_LEN) begin
         eff_len = MAX_LEN;
      end
   end

   assign sum_next = running_sum_ff + rx_byte;

   always_comb begin
      byte_index_in  = byte_index_ff;
      running_sum_in = running_sum_ff;
      rel_count_in   = rel_count_ff;
      rd_ptr_in      = rd_ptr_ff;
      if (cmd.frame_start) begin
         byte_index_in  = '0;
         running_sum_in = rx_byte;
      end
      if (cmd.store_byte) begin
         byte_index_in  = byte_index_ff + 1'b1;
         running_sum_in = sum_next;
      end
      if (cmd.frame_pass || cmd.frame_fail) begin
         byte_index_in  = '0;
         running_sum_in = '0;
      end
      if (cmd.frame_pass) begin
         rel_count_in = byte_index_ff;
         rd_ptr_in    = '0;
      end
      if (cmd.rd_advance) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff  <= '0;
         payload_len_ff <= lrc_pkg::LEN_W'(1);
         byte_index_ff  <= '0;
         running_sum_ff <= '0;
      end else begin
         start_byte_ff  <= start_byte_in;
         payload_len_ff <= payload_len_in;
         byte_index_ff  <= byte_index_in;
         running_sum_ff <= running_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      rel_count_ff <= rel_count_in;
      rd_ptr_ff    <= rd_ptr_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.store_byte) begin
         frame_store[byte_index_ff[IDX_W-1:0]] <= rx_byte;
      end
      rd_data_ff <= frame_store[rd_ptr_ff[IDX_W-1:0]];
   end

   assign stat.start_match = (rx_byte == start_byte_ff);
   assign stat.index_full  = ({1'b0, byte_index_ff} >= eff_len);
   assign stat.sum_ok      = (sum_next == '0) && (byte_index_ff != '0);
   assign stat.last_read   = (({1'b0, rd_ptr_ff} + 1'b1) == {1'b0, rel_count_ff});

   assign payload_byte  = cmd.sel_error ? '0 : rd_data_ff;
   assign status        = cmd.sel_error ? lrc_pkg::STATUS_MISMATCH : lrc_pkg::STATUS_OK;
   assign last_of_frame = cmd.sel_error | stat.last_read;

endmodule

// ===== hdl/lrc_controller.sv =====
// ---------------------------------------------------------------------------
// lrc_controller
// Hunt, collect, verify and release sequencing of the frame receiver.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lrc_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   output logic                     out_valid,
   input  logic                     out_ready,
   input  lrc_pkg::ctl_status_type  stat,
   output lrc_pkg::ctl_cmd_type     cmd
);

   lrc_pkg::state_type state_ff, state_in;
   logic in_acc, out_acc;

   assign in_acc  = in_valid && in_ready;
   assign out_acc = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lrc_pkg::ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      in_ready  = 1'b0;
      out_valid = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         lrc_pkg::ST_HUNT: begin
            in_ready = 1'b1;
            if (in_valid && stat.start_match) begin
               cmd.frame_start = 1'b1;
               state_in        = lrc_pkg::ST_COLLECT;
            end
         end
         lrc_pkg::ST_COLLECT: begin
            in_ready = 1'b1;
            if (in_valid) begin
               if (!stat.index_full) begin
                  cmd.store_byte = 1'b1;
               end else if (stat.sum_ok) begin
                  cmd.frame_pass = 1'b1;
                  state_in       = lrc_pkg::ST_READ;
               end else begin
                  cmd.frame_fail = 1'b1;
                  state_in       = lrc_pkg::ST_SHOW_ERROR;
               end
            end
         end
         lrc_pkg::ST_READ: begin
            state_in = lrc_pkg::ST_SHOW_DATA;
         end
         lrc_pkg::ST_SHOW_DATA: begin
            out_valid = 1'b1;
            if (out_ready) begin
               if (stat.last_read) begin
                  state_in = lrc_pkg::ST_HUNT;
               end else begin
                  cmd.rd_advance = 1'b1;
                  state_in       = lrc_pkg::ST_READ;
               end
            end
         end
         lrc_pkg::ST_SHOW_ERROR: begin
            out_valid     = 1'b1;
            cmd.sel_error = 1'b1;
            if (out_ready) begin
               state_in = lrc_pkg::ST_HUNT;
            end
         end
         default: begin
            state_in = lrc_pkg::ST_HUNT;
         end
      endcase
   end

   `ASSERT_NEVER(a_no_overlap, clock, reset, in_ready && out_valid, "input and output both open")
   `ASSERT_CLK(a_read_then_show, clock, reset, (state_ff == lrc_pkg::ST_READ) |=> (state_ff == lrc_pkg::ST_SHOW_DATA), "read not followed by show")
   `ASSERT_CLK(a_last_to_hunt, clock, reset, (out_acc && (state_ff == lrc_pkg::ST_SHOW_DATA) && stat.last_read) |=> (state_ff == lrc_pkg::ST_HUNT), "frame end did not return to hunt")
   `ASSERT_CLK(a_fail_to_error, clock, reset, (in_acc && cmd.frame_fail) |=> (state_ff == lrc_pkg::ST_SHOW_ERROR), "mismatch did not raise error word")

endmodule

// ===== hdl/lrc_frame_receiver.sv =====
// A verified frame's first word is shown once the controller has moved from ST_READ, where
// the frame store's registered read port is loaded, to ST_SHOW_DATA; an error word appears
// in the cycle after the checksum byte is taken. Each payload word goes through ST_READ and
// ST_SHOW_DATA. Bytes are taken one per cycle in hunt/collect, none during release.
// Reset (synchronous, active high) returns to hunting, start_byte 0, payload_len 1.
// ---------------------------------------------------------------------------
// lrc_frame_receiver
// Start-byte framed receiver with LRC check and payload release.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrc_frame_receiver #(
   parameter int MAX_PAYLOAD = lrc_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wen,
   input  logic [lrc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lrc_pkg::BYTE_W-1:0]      csr_wdata,
   lrc_req_if.sink                         req_chan,
   lrc_rsp_if.source                       rsp_chan
);

   lrc_pkg::ctl_cmd_type    cmd;
   lrc_pkg::ctl_status_type stat;

   lrc_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lrc_datapath #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_wen       (csr_wen),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rx_byte       (req_chan.rx_byte),
      .cmd           (cmd),
      .stat          (stat),
      .payload_byte  (rsp_chan.payload_byte),
      .status        (rsp_chan.status),
      .last_of_frame (rsp_chan.last_of_frame)
   );

endmodule

// ===== tb/lrc_frame_receiver_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lrc_frame_receiver_tb
// Drives received bytes into the frame receiver: framed runs with good and
// corrupted LRC bytes, noise between frames, and register changes both
// between frames and in the middle of one. A byte-level model predicts the
// released words, and each word taken from the result channel is checked
// against the oldest prediction. The sender runs in random bursts, and the
// result side stalls on rotating ready patterns.
// ---------------------------------------------------------------------------

module lrc_frame_receiver_tb;

   localparam int FRAME_MAX     = lrc_pkg::MAX_PAYLOAD_DEF;
   localparam int FRAME_IDX_W   = $clog2(FRAME_MAX);
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 200000;

   typedef struct packed {
      logic [lrc_pkg::BYTE_W-1:0] payload_byte;
      logic                       status;
      logic                       last_of_frame;
   } rsp_word_type;

   typedef struct {
      logic [lrc_pkg::BYTE_W-1:0] rx_byte;
      bit                         hold_until_drained;
   } link_byte_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_wen;
   logic [lrc_pkg::CSR_IDX_W-1:0] csr_index;
   logic [lrc_pkg::BYTE_W-1:0]    csr_wdata;

   lrc_req_if req_if();
   lrc_rsp_if rsp_if();

   lrc_frame_receiver dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model state and register copies
   logic [lrc_pkg::BYTE_W-1:0] cfg_start;
   logic [lrc_pkg::LEN_W-1:0]  cfg_len;
   bit                         in_frame;
   logic [lrc_pkg::LEN_W-1:0]  frame_count;
   logic [lrc_pkg::BYTE_W-1:0] frame_sum;
   logic [lrc_pkg::BYTE_W-1:0] frame_bytes [FRAME_MAX];

   link_byte_type link_bytes [$];
   rsp_word_type  awaited_words [$];

   int bytes_queued;
   int bytes_taken;
   int frames_released;
   int frames_dropped;
   int words_checked;
   int settings_used;
   int fault_count;
   int cycle_count;

   int                         burst_left = 8;
   int                         gap_left;
   logic                       drv_show;
   logic [lrc_pkg::BYTE_W-1:0] drv_data;
   logic [15:0]                stall_pattern;
   int                         pattern_age;
   rsp_word_type               mon_got;
   rsp_word_type               mon_want;

   function automatic int frame_span(input logic [lrc_pkg::LEN_W-1:0] len);
      if (int'(len) == 0) return 1;
      if (int'(len) > FRAME_MAX) return FRAME_MAX;
      return int'(len);
   endfunction

   task automatic absorb_rx_byte(input logic [lrc_pkg::BYTE_W-1:0] b);
      logic [lrc_pkg::BYTE_W-1:0] check;
      int                         n;
      rsp_word_type               w;
      if (!in_frame) begin
         if (b == cfg_start) begin
            in_frame    = 1'b1;
            frame_count = '0;
            frame_sum   = b;
         end
      end else if (int'(frame_count) < frame_span(cfg_len)) begin
         frame_bytes[frame_count[FRAME_IDX_W-1:0]] = b;
         frame_sum   = frame_sum + b;
         frame_count = frame_count + 1'b1;
      end else begin
         in_frame    = 1'b0;
         n           = (int'(frame_count) > FRAME_MAX) ? FRAME_MAX : int'(frame_count);
         frame_count = '0;
         check       = frame_sum + b;
         frame_sum   = '0;
         if (check != '0 || n == 0) begin
            w.payload_byte  = '0;
            w.status        = lrc_pkg::STATUS_MISMATCH;
            w.last_of_frame = 1'b1;
            awaited_words.push_back(w);
            frames_dropped++;
         end else begin
            for (int k = 0; k < n; k++) begin
               w.payload_byte  = frame_bytes[k[FRAME_IDX_W-1:0]];
               w.status        = lrc_pkg::STATUS_OK;
               w.last_of_frame = (k == n - 1);
               awaited_words.push_back(w);
            end
            frames_released++;
         end
      end
   endtask

   // sender: bursts of random length, random gaps between them
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.rx_byte <= '0;
         in_frame       = 1'b0;
         frame_count    = '0;
         frame_sum      = '0;
      end else begin
         drv_show = req_if.valid;
         drv_data = req_if.rx_byte;
         if (req_if.valid && req_if.ready) begin
            absorb_rx_byte(req_if.rx_byte);
            bytes_taken++;
            drv_show = 1'b0;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            end
         end
         if (!drv_show) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (link_bytes.size() != 0 &&
                         !(link_bytes[0].hold_until_drained && awaited_words.size() != 0)) begin
               drv_data = link_bytes[0].rx_byte;
               link_bytes.delete(0);
               drv_show = 1'b1;
            end
         end
         req_if.valid   <= drv_show;
         req_if.rx_byte <= drv_data;
      end
   end

   // receiver: rotate a stall pattern, swap it now and then
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready  <= 1'b0;
         stall_pattern = 16'hFFFF;
         pattern_age   = 0;
      end else begin
         if (pattern_age == 0) begin
            pattern_age = $urandom_range(20, 80);
            case ($urandom_range(0, 3))
               0: begin
                  stall_pattern = 16'hFFFF;
               end
               1: begin
                  stall_pattern = 16'h8001;
               end
               default: begin
                  stall_pattern = 16'($urandom) | 16'h0001;
               end
            endcase
         end
         pattern_age--;
         stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
         rsp_if.ready <= stall_pattern[0];
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         mon_got.payload_byte  = rsp_if.payload_byte;
         mon_got.status        = rsp_if.status;
         mon_got.last_of_frame = rsp_if.last_of_frame;
         if (awaited_words.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("unexpected word: byte %02h status %0d last %0d",
                        mon_got.payload_byte, mon_got.status, mon_got.last_of_frame);
         end else begin
            mon_want = awaited_words.pop_front();
            words_checked++;
            if (mon_got.payload_byte !== mon_want.payload_byte ||
                mon_got.status !== mon_want.status ||
                mon_got.last_of_frame !== mon_want.last_of_frame) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("word %0d: expected byte %02h status %0d last %0d, got %02h %0d %0d",
                           words_checked, mon_want.payload_byte, mon_want.status,
                           mon_want.last_of_frame, mon_got.payload_byte, mon_got.status,
                           mon_got.last_of_frame);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                  awaited_words.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic push_byte(input logic [lrc_pkg::BYTE_W-1:0] b, input bit hold);
      link_byte_type e;
      e.rx_byte            = b;
      e.hold_until_drained = hold;
      link_bytes.push_back(e);
      bytes_queued++;
   endtask

   task automatic wait_link_idle();
      do @(posedge clock);
      while (link_bytes.size() != 0 || req_if.valid || awaited_words.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [lrc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [lrc_pkg::BYTE_W-1:0] data);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wen <= 1'b0;
      if (idx == lrc_pkg::REG_START_BYTE) cfg_start = data;
      else cfg_len = data[lrc_pkg::LEN_W-1:0];
      settings_used++;
   endtask

   task automatic queue_frame(input logic [lrc_pkg::BYTE_W-1:0] sof, input int span,
                              input bit corrupt, input bit hold);
      logic [lrc_pkg::BYTE_W-1:0] sum;
      logic [lrc_pkg::BYTE_W-1:0] b;
      push_byte(sof, hold);
      sum = sof;
      for (int i = 0; i < span; i++) begin
         b   = 8'($urandom_range(0, 255));
         sum = sum + b;
         push_byte(b, 1'b0);
      end
      b = -sum;
      if (corrupt) b = b ^ 8'($urandom_range(1, 255));
      push_byte(b, 1'b0);
   endtask

   task automatic run_phase(input logic [lrc_pkg::BYTE_W-1:0] sof,
                            input logic [lrc_pkg::LEN_W-1:0] len,
                            input int budget, input bit force_hold);
      int mark;
      int frames;
      int pick;
      logic [lrc_pkg::BYTE_W-1:0] b;
      wait_link_idle();
      write_reg(lrc_pkg::REG_START_BYTE, sof);
      write_reg(lrc_pkg::REG_PAYLOAD_LEN, {2'b00, len});
      mark   = bytes_queued;
      frames = 0;
      while (bytes_queued - mark < budget) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            repeat ($urandom_range(1, 3)) begin
               b = 8'($urandom_range(0, 255));
               if (b == sof) b = ~b;
               push_byte(b, 1'b0);
            end
         end else begin
            queue_frame(sof, frame_span(len), pick == 1,
                        frames == 1 && (force_hold || $urandom_range(0, 3) == 0));
            frames++;
         end
      end
   endtask

   initial begin
      logic [lrc_pkg::LEN_W-1:0] phase_len [7];
      csr_wen        <= 1'b0;
      csr_index      <= '0;
      csr_wdata      <= '0;
      cfg_start      = '0;
      cfg_len        = 6'd1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: start 00, one payload byte
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'h01, 1'b0);
      push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0); push_byte(8'h7F, 1'b0); push_byte(8'h00, 1'b0);
      wait_link_idle();
      write_reg(lrc_pkg::REG_START_BYTE, 8'hFF);
      write_reg(lrc_pkg::REG_PAYLOAD_LEN, 8'd0);
      push_byte(8'hFF, 1'b0); push_byte(8'h01, 1'b0); push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0); push_byte(8'h80, 1'b0); push_byte(8'h81, 1'b0);
      wait_link_idle();
      write_reg(lrc_pkg::REG_START_BYTE, 8'hA5);
      write_reg(lrc_pkg::REG_PAYLOAD_LEN, 8'd3);
      push_byte(8'hA5, 1'b0); push_byte(8'h11, 1'b0); push_byte(8'h22, 1'b0);
      // shorten the length and move the start byte while the frame is open
      wait_link_idle();
      write_reg(lrc_pkg::REG_PAYLOAD_LEN, 8'd2);
      write_reg(lrc_pkg::REG_START_BYTE, 8'h3C);
      push_byte(8'h28, 1'b0);
      push_byte(8'h3C, 1'b1); push_byte(8'h55, 1'b0); push_byte(8'hAA, 1'b0);
      push_byte(8'hC5, 1'b0);

      phase_len = '{6'd3, 6'd63, 6'd1, 6'd6, 6'd32, 6'd2, 6'($urandom_range(1, 8))};
      for (int p = 0; p < 7; p++)
         run_phase(8'($urandom_range(0, 255)), phase_len[p],
                   (phase_len[p] > 8) ? 1 : 8, p == 2);

      wait_link_idle();
      $display("sent %0d link bytes over %0d register writes", bytes_taken, settings_used);
      $display("%0d frames released, %0d dropped, %0d words checked, %0d faults",
               frames_released, frames_dropped, words_checked, fault_count);
      if (fault_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
